@@ rtl/tfp_pkg.sv @@
package tfp_pkg;

	localparam int LENGTH_BITS = 32;
	localparam logic [31:0] LENGTH_LIMIT = 32'((64'd1 << LENGTH_BITS) - 64'd1);

	localparam logic [3:0] PH_HEADER    = 4'd0;
	localparam logic [3:0] PH_ERRCODE   = 4'd1;
	localparam logic [3:0] PH_EVENT     = 4'd2;
	localparam logic [3:0] PH_SESS_LEN  = 4'd3;
	localparam logic [3:0] PH_SESS_DATA = 4'd4;
	localparam logic [3:0] PH_CONN_LEN  = 4'd5;
	localparam logic [3:0] PH_CONN_DATA = 4'd6;
	localparam logic [3:0] PH_PAY_LEN   = 4'd7;
	localparam logic [3:0] PH_PAY_DATA  = 4'd8;
	localparam logic [3:0] PH_TRAIL     = 4'd9;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_HEADER    = 3'd1;
	localparam logic [2:0] ST_ERRCODE   = 3'd2;
	localparam logic [2:0] ST_EVENT     = 3'd3;
	localparam logic [2:0] ST_SESSION   = 3'd4;
	localparam logic [2:0] ST_CONN      = 3'd5;
	localparam logic [2:0] ST_PAYLOAD   = 3'd6;

	localparam logic [3:0] TYPE_ERROR = 4'hf;
	localparam logic [3:0] FLAG_EVENT = 4'h4;

	localparam logic [31:0] EV_START_CONN    = 32'd1;
	localparam logic [31:0] EV_FINISH_CONN   = 32'd2;
	localparam logic [31:0] EV_CONN_STARTED  = 32'd50;
	localparam logic [31:0] EV_CONN_FAILED   = 32'd51;
	localparam logic [31:0] EV_CONN_FINISHED = 32'd52;

	localparam int TDATA_BITS = 88;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  value;
		logic        fend;
		logic        last;
		logic [3:0]  phase_next;
		logic [3:0]  type_nib;
		logic [3:0]  flag_nib;
		logic [31:0] event_word;
		logic [31:0] error_word;
	} tfp_item_t;

	function automatic logic [3:0] after_event(input logic [31:0] ev);
		if (ev == EV_CONN_STARTED || ev == EV_CONN_FAILED || ev == EV_CONN_FINISHED)
			return PH_CONN_LEN;
		if (ev == EV_START_CONN || ev == EV_FINISH_CONN)
			return PH_PAY_LEN;
		return PH_SESS_LEN;
	endfunction

	function automatic logic [2:0] short_status(input logic [3:0] ph);
		logic [2:0] st;
		unique case (ph)
			PH_HEADER:                 st = ST_HEADER;
			PH_ERRCODE:                st = ST_ERRCODE;
			PH_EVENT:                  st = ST_EVENT;
			PH_SESS_LEN, PH_SESS_DATA: st = ST_SESSION;
			PH_CONN_LEN, PH_CONN_DATA: st = ST_CONN;
			PH_PAY_LEN, PH_PAY_DATA:   st = ST_PAYLOAD;
			default:                   st = ST_OK;
		endcase
		return st;
	endfunction

endpackage

@@ rtl/tfp_front.sv @@
module tfp_front import tfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  logic [7:0] data_byte,
	input  logic      last_byte,
	output tfp_item_t item
);

	logic [3:0]             phase_q, phase_nx;
	logic [1:0]             count_q, count_nx;
	logic [31:0]            accum_q, accum_nx;
	logic [LENGTH_BITS-1:0] remain_q, remain_nx;
	logic [3:0]             type_q, type_nx;
	logic [3:0]             flag_q, flag_nx;
	logic [31:0]            event_q, event_nx;
	logic [31:0]            error_q, error_nx;
	logic [3:0]             kind;
	logic                   fend;
	logic [31:0]            shifted;
	logic [31:0]            sat_len;

	assign kind    = (phase_q > PH_TRAIL) ? PH_TRAIL : phase_q;
	assign shifted = {accum_q[23:0], data_byte};
	assign sat_len = (shifted > LENGTH_LIMIT) ? LENGTH_LIMIT : shifted;

	always_comb begin
		phase_nx  = phase_q;
		count_nx  = count_q;
		accum_nx  = accum_q;
		remain_nx = remain_q;
		type_nx   = type_q;
		flag_nx   = flag_q;
		event_nx  = event_q;
		error_nx  = error_q;
		fend      = 1'b0;
		unique case (kind)
			PH_HEADER: begin
				if (count_q == 2'd1) begin
					type_nx = data_byte[7:4];
					flag_nx = data_byte[3:0];
				end
				count_nx = count_q + 2'd1;
				if (count_q == 2'd3) begin
					fend = 1'b1;
					if (type_q == TYPE_ERROR)
						phase_nx = PH_ERRCODE;
					else if (flag_q == FLAG_EVENT)
						phase_nx = PH_EVENT;
					else
						phase_nx = PH_PAY_LEN;
				end
			end
			PH_ERRCODE, PH_EVENT, PH_SESS_LEN, PH_CONN_LEN, PH_PAY_LEN: begin
				accum_nx = shifted;
				count_nx = count_q + 2'd1;
				if (count_q == 2'd3) begin
					fend     = 1'b1;
					accum_nx = '0;
					if (kind == PH_ERRCODE) begin
						error_nx = shifted;
						phase_nx = (flag_q == FLAG_EVENT) ? PH_EVENT : PH_PAY_LEN;
					end else if (kind == PH_EVENT) begin
						event_nx = shifted;
						phase_nx = after_event(shifted);
					end else begin
						remain_nx = sat_len[LENGTH_BITS-1:0];
						if (sat_len != '0)
							phase_nx = kind + 4'd1;
						else
							phase_nx = (kind == PH_PAY_LEN) ? PH_TRAIL : PH_PAY_LEN;
					end
				end
			end
			PH_SESS_DATA, PH_CONN_DATA, PH_PAY_DATA: begin
				if (remain_q != '0)
					remain_nx = remain_q - LENGTH_BITS'(1);
				if (remain_nx == '0) begin
					fend     = 1'b1;
					phase_nx = (kind == PH_PAY_DATA) ? PH_TRAIL : PH_PAY_LEN;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		item.kind       = kind;
		item.value      = data_byte;
		item.fend       = fend;
		item.last       = last_byte;
		item.phase_next = phase_nx;
		item.type_nib   = type_nx;
		item.flag_nib   = flag_nx;
		item.event_word = event_nx;
		item.error_word = error_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			count_q  <= '0;
			accum_q  <= '0;
			remain_q <= '0;
			type_q   <= '0;
			flag_q   <= '0;
			event_q  <= '0;
			error_q  <= '0;
		end else if (take) begin
			if (last_byte) begin
				phase_q  <= PH_HEADER;
				count_q  <= '0;
				accum_q  <= '0;
				remain_q <= '0;
				type_q   <= '0;
				flag_q   <= '0;
				event_q  <= '0;
				error_q  <= '0;
			end else begin
				phase_q  <= phase_nx;
				count_q  <= count_nx;
				accum_q  <= accum_nx;
				remain_q <= remain_nx;
				type_q   <= type_nx;
				flag_q   <= flag_nx;
				event_q  <= event_nx;
				error_q  <= error_nx;
			end
		end
	end

endmodule

@@ rtl/tfp_queue.sv @@
module tfp_queue import tfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tfp_item_t push_item,
	output logic      not_full,
	input  logic      pop,
	output logic      not_empty,
	output tfp_item_t pop_item
);

	tfp_item_t  slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign not_full  = (fill_q != 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_item  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= ~wr_q;
			if (do_pop)
				rd_q <= ~rd_q;
			fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

@@ rtl/tfp_back.sv @@
module tfp_back import tfp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  have_item,
	input  tfp_item_t             item,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [TDATA_BITS-1:0] out_data,
	output logic [3:0]            out_kind,
	output logic                  out_last
);

	logic                  valid_q;
	logic [TDATA_BITS-1:0] data_q;
	logic [3:0]            kind_q;
	logic                  last_q;
	logic [2:0]            status;

	assign pop    = have_item && (!valid_q || out_ready);
	assign status = item.last ? short_status(item.phase_next) : ST_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || out_ready)
			valid_q <= have_item;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= {4'd0, item.error_word, item.event_word, item.flag_nib,
				item.type_nib, status, item.fend, item.value};
			kind_q <= item.kind;
			last_q <= item.last;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

endmodule

@@ rtl/tts_frame_parser.sv @@
// A transaction accepted on the slave side is written into the queue, then moved into the
// output register and presented on the master side. Throughput: one byte per cycle, sustained
// while the queue has room; the front parser updates its state once per byte.
// A two-entry queue sits between the parser and the output register, so either side may stall.
// Reset is asynchronous and active low; it returns the parser to the header phase and empties
// the queue and the output register.
module tts_frame_parser import tfp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // data_byte[7:0]
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// byte_value[7:0], field_end[8], parse_status[11:9], message_type[15:12],
	// message_flag[19:16], event_code[51:20], error_value[83:52], zero fill[87:84]
	output logic [TDATA_BITS-1:0] m_axis_tdata,
	output logic [3:0]            m_axis_tuser,  // byte_kind[3:0]
	output logic                  m_axis_tlast
);

	tfp_item_t front_item;
	tfp_item_t head_item;
	logic      take;
	logic      q_not_full;
	logic      q_not_empty;
	logic      q_pop;

	assign s_axis_tready = q_not_full;
	assign take          = s_axis_tvalid && q_not_full;

	tfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (s_axis_tdata),
		.last_byte (s_axis_tlast),
		.item      (front_item)
	);

	tfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_item (front_item),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_item  (head_item)
	);

	tfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.have_item (q_not_empty),
		.item      (head_item),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

@@ test/tts_frame_parser_tb.sv @@
`timescale 1ns / 100ps

import tfp_pkg::*;

typedef struct {
	logic [3:0]  kind;
	logic [7:0]  value;
	logic        fend;
	logic        msg_end;
	logic [2:0]  status;
	logic [3:0]  mtype;
	logic [3:0]  mflag;
	logic [31:0] evt;
	logic [31:0] err;
} parsed_byte_t;

class frame_parse_checker;
	logic [3:0]   phase;
	logic [1:0]   fixed_count;
	logic [31:0]  accum;
	logic [31:0]  remaining;
	logic [3:0]   type_nib;
	logic [3:0]   flag_nib;
	logic [31:0]  event_word;
	logic [31:0]  error_word;
	parsed_byte_t expected_bytes[$];
	int           errors;

	function new();
		errors = 0;
		clear_state();
	endfunction

	function void clear_state();
		phase = PH_HEADER;
		fixed_count = 2'd0;
		accum = 32'd0;
		remaining = 32'd0;
		type_nib = 4'd0;
		flag_nib = 4'd0;
		event_word = 32'd0;
		error_word = 32'd0;
	endfunction

	function int pending();
		return expected_bytes.size();
	endfunction

	function void absorb_byte(logic [7:0] b, logic is_last);
		parsed_byte_t e;
		logic [3:0] kind;
		logic fend;
		logic done4;
		kind = (phase > PH_TRAIL) ? PH_TRAIL : phase;
		fend = 1'b0;
		case (kind)
			PH_HEADER: begin
				if (fixed_count == 2'd1) begin
					type_nib = b[7:4];
					flag_nib = b[3:0];
				end
				if (fixed_count == 2'd3) begin
					fend = 1'b1;
					fixed_count = 2'd0;
					if (type_nib == TYPE_ERROR)
						phase = PH_ERRCODE;
					else if (flag_nib == FLAG_EVENT)
						phase = PH_EVENT;
					else
						phase = PH_PAY_LEN;
				end else begin
					fixed_count = fixed_count + 2'd1;
				end
			end
			PH_ERRCODE, PH_EVENT, PH_SESS_LEN, PH_CONN_LEN, PH_PAY_LEN: begin
				accum = {accum[23:0], b};
				done4 = (fixed_count == 2'd3);
				fixed_count = fixed_count + 2'd1;
				if (done4) begin
					fend = 1'b1;
					if (kind == PH_ERRCODE) begin
						error_word = accum;
						phase = (flag_nib == FLAG_EVENT) ? PH_EVENT : PH_PAY_LEN;
					end else if (kind == PH_EVENT) begin
						event_word = accum;
						case (accum)
							EV_CONN_STARTED, EV_CONN_FAILED, EV_CONN_FINISHED:
								phase = PH_CONN_LEN;
							EV_START_CONN, EV_FINISH_CONN:
								phase = PH_PAY_LEN;
							default:
								phase = PH_SESS_LEN;
						endcase
					end else begin
						remaining = (accum > LENGTH_LIMIT) ? LENGTH_LIMIT : accum;
						if (remaining != 32'd0)
							phase = 4'(kind + 4'd1);
						else
							phase = (kind == PH_PAY_LEN) ? PH_TRAIL : PH_PAY_LEN;
					end
					accum = 32'd0;
				end
			end
			PH_SESS_DATA, PH_CONN_DATA, PH_PAY_DATA: begin
				if (remaining != 32'd0)
					remaining = remaining - 32'd1;
				if (remaining == 32'd0) begin
					fend = 1'b1;
					phase = (kind == PH_PAY_DATA) ? PH_TRAIL : PH_PAY_LEN;
				end
			end
			default: begin
			end
		endcase
		e.kind = kind;
		e.value = b;
		e.fend = fend;
		e.msg_end = is_last;
		e.status = ST_OK;
		if (is_last) begin
			case (phase)
				PH_HEADER:                 e.status = ST_HEADER;
				PH_ERRCODE:                e.status = ST_ERRCODE;
				PH_EVENT:                  e.status = ST_EVENT;
				PH_SESS_LEN, PH_SESS_DATA: e.status = ST_SESSION;
				PH_CONN_LEN, PH_CONN_DATA: e.status = ST_CONN;
				PH_PAY_LEN, PH_PAY_DATA:   e.status = ST_PAYLOAD;
				default:                   e.status = ST_OK;
			endcase
		end
		e.mtype = type_nib;
		e.mflag = flag_nib;
		e.evt = event_word;
		e.err = error_word;
		expected_bytes.insert(expected_bytes.size(), e);
		if (is_last)
			clear_state();
	endfunction

	function void check_field(string label, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
			errors++;
		end
	endfunction

	function void match_output(logic [TDATA_BITS-1:0] tdata, logic [3:0] tuser, logic tlast);
		parsed_byte_t e;
		if (expected_bytes.size() == 0) begin
			$display("%0t: unexpected transaction, expected none, actual tdata %0h", $time,
				tdata);
			errors++;
		end else begin
			e = expected_bytes[0];
			expected_bytes.delete(0);
			check_field("byte_kind", 32'(e.kind), 32'(tuser));
			check_field("byte_value", 32'(e.value), 32'(tdata[7:0]));
			check_field("field_end", 32'(e.fend), 32'(tdata[8]));
			check_field("message_end", 32'(e.msg_end), 32'(tlast));
			check_field("parse_status", 32'(e.status), 32'(tdata[11:9]));
			check_field("message_type", 32'(e.mtype), 32'(tdata[15:12]));
			check_field("message_flag", 32'(e.mflag), 32'(tdata[19:16]));
			check_field("event_code", e.evt, tdata[51:20]);
			check_field("error_value", e.err, tdata[83:52]);
			check_field("zero fill", 32'd0, 32'(tdata[87:84]));
		end
	endfunction
endclass

module tts_frame_parser_tb;
	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [TDATA_BITS-1:0] m_axis_tdata;
	logic [3:0]            m_axis_tuser;
	logic                  m_axis_tlast;

	frame_parse_checker checker_h;
	logic [7:0]         msg_bytes[$];
	int                 bytes_sent;
	bit                 tx_calm;
	bit                 rx_calm;
	int                 quiet_cycles;

	tts_frame_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void append_byte(logic [7:0] b);
		msg_bytes.insert(msg_bytes.size(), b);
	endfunction

	function automatic void push_word(logic [31:0] w);
		append_byte(w[31:24]);
		append_byte(w[23:16]);
		append_byte(w[15:8]);
		append_byte(w[7:0]);
	endfunction

	// Returns 1 when the string is cut short because its length is too large to send.
	function automatic bit push_string();
		logic [31:0] len;
		int n;
		len = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6);
		push_word(len);
		n = (len > 32'd8) ? $urandom_range(0, 8) : int'(len);
		repeat (n) append_byte(8'($urandom));
		return len > 32'd8;
	endfunction

	function automatic void build_message();
		logic [3:0] mtype;
		logic [3:0] mflag;
		logic [31:0] ev;
		bit cut;
		int keep;
		msg_bytes.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
			return;
		end
		mtype = ($urandom_range(0, 3) == 0) ? TYPE_ERROR : 4'($urandom);
		mflag = ($urandom_range(0, 1) == 0) ? FLAG_EVENT : 4'($urandom);
		append_byte(8'($urandom));
		append_byte({mtype, mflag});
		append_byte(8'($urandom));
		append_byte(8'($urandom));
		if (mtype == TYPE_ERROR)
			push_word($urandom);
		cut = 1'b0;
		if (mflag == FLAG_EVENT) begin
			case ($urandom_range(0, 5))
				0:       ev = EV_START_CONN;
				1:       ev = EV_FINISH_CONN;
				2:       ev = EV_CONN_STARTED;
				3:       ev = EV_CONN_FAILED;
				4:       ev = EV_CONN_FINISHED;
				default: ev = $urandom;
			endcase
			push_word(ev);
			if (ev != EV_START_CONN && ev != EV_FINISH_CONN)
				cut = push_string();
		end
		if (!cut)
			cut = push_string();
		if (!cut)
			repeat ($urandom_range(0, 2)) append_byte(8'($urandom));
		if ($urandom_range(0, 4) == 0) begin
			keep = $urandom_range(1, msg_bytes.size());
			while (msg_bytes.size() > keep) msg_bytes.pop_back();
		end
	endfunction

	task automatic send_byte(input logic [7:0] value, input logic is_last);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tlast <= is_last;
		do @(posedge clk); while (!s_axis_tready);
		checker_h.absorb_byte(value, is_last);
		bytes_sent++;
	endtask

	task automatic send_message();
		int i;
		tx_calm = ($urandom_range(0, 3) == 0);
		for (i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
	endtask

	initial begin
		checker_h = new();
		bytes_sent = 0;
		tx_calm = 1'b0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'd0;
		s_axis_tlast <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A lone byte gives a short header.
		msg_bytes.delete();
		append_byte(8'h5a);
		send_message();

		// Error type with an event that needs a connection id, an empty payload and a
		// trailing byte.
		msg_bytes.delete();
		append_byte(8'h00);
		append_byte({TYPE_ERROR, FLAG_EVENT});
		append_byte(8'h00);
		append_byte(8'h00);
		push_word(32'hffff_ffff);
		push_word(EV_CONN_FAILED);
		push_word(32'd1);
		append_byte(8'haa);
		push_word(32'd0);
		append_byte(8'h55);
		send_message();

		while (bytes_sent < 1000) begin
			build_message();
			send_message();
		end
		s_axis_tvalid <= 1'b0;

		while (checker_h.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (checker_h.errors == 0)
			$display("tts_frame_parser_tb passed");
		else
			$display("tts_frame_parser_tb failed");
		$finish;
	end

	initial begin
		int gap;
		rx_calm = 1'b0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
			gap = rx_calm ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			checker_h.match_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= 5000) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
				$display("tts_frame_parser_tb failed");
				$finish;
			end
		end
	end
endmodule
